@@ hw/rtl/ctks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctks_pkg: shared types and constants of the cosine top-k search core
// Field widths, register indexes and the kept-entry record of the chain.
// ----------------------------------------------------------------------------
package ctks_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_X      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_Y      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_Z      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RESULT_COUNT = 2'd3;

    localparam int COMP_W  = 16;
    localparam int QUERY_W = 18;
    localparam int SCORE_W = 18;
    localparam int INDEX_W = 24;
    localparam int HASH_W  = 64;
    localparam int LP_W    = 11;
    localparam int RC_W    = 7;
    localparam int RANK_W  = 6;

    localparam int SCORE_MAX = 65536;
    localparam int DEFAULT_K = 5;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [INDEX_W-1:0]        index;
        logic [HASH_W-1:0]         hash;
        logic [HASH_W-1:0]         docref;
        logic [LP_W-1:0]           lp;
    } t_entry;

    typedef struct packed {
        logic ins;    // insert the broadcast record
        logic shift;  // move every entry one place toward the head
    } t_cell_ctrl;

endpackage

@@ hw/rtl/ctks_scorer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctks_scorer: cosine score of one record
// Sequential dot product and norm, bit-serial square root and divider.
// ----------------------------------------------------------------------------
module ctks_scorer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ctks_pkg::QUERY_W-1:0]    i_qx,
    input  logic signed [ctks_pkg::QUERY_W-1:0]    i_qy,
    input  logic signed [ctks_pkg::QUERY_W-1:0]    i_qz,
    input  logic [ctks_pkg::COMP_W-1:0]            i_cx,
    input  logic [ctks_pkg::COMP_W-1:0]            i_cy,
    input  logic [ctks_pkg::COMP_W-1:0]            i_cz,
    output logic                                   o_done,
    output logic signed [ctks_pkg::SCORE_W-1:0]    o_score
);

    typedef enum logic [2:0] {SC_IDLE, SC_MUL, SC_SQRT, SC_DIV, SC_DONE} t_sc_state;

    t_sc_state r_state;
    logic [5:0] r_step;
    logic [ctks_pkg::COMP_W-1:0] r_cx, r_cy, r_cz;
    logic signed [34:0] r_pd;
    logic [31:0] r_pn;
    logic signed [36:0] r_dot;
    logic [33:0] r_n2;
    logic [61:0] r_rad;
    logic [34:0] r_rem;
    logic [30:0] r_root;
    logic [51:0] r_num;
    logic [32:0] r_drem;
    logic [51:0] r_quo;
    logic r_neg;
    logic [36:0] r_mag;
    logic signed [ctks_pkg::SCORE_W-1:0] r_score;

    logic signed [ctks_pkg::QUERY_W-1:0] w_q;
    logic [ctks_pkg::COMP_W-1:0] w_c;
    logic signed [36:0] w_dot_sum;
    logic [33:0] w_n2_sum;
    logic [34:0] w_rem_sh, w_trial;
    logic [32:0] w_drem_sh, w_den;
    logic [51:0] w_quo_next;

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    begin w_q = i_qx; w_c = r_cx; end
            2'd1:    begin w_q = i_qy; w_c = r_cy; end
            default: begin w_q = i_qz; w_c = r_cz; end
        endcase
        w_dot_sum  = r_dot + 37'(r_pd);
        w_n2_sum   = r_n2 + 34'(r_pn);
        w_rem_sh   = {r_rem[32:0], r_rad[61:60]};
        w_trial    = {2'b00, r_root, 2'b01};
        w_den      = {1'b0, r_root, 1'b0};
        w_drem_sh  = {r_drem[31:0], r_num[51]};
        w_quo_next = {r_quo[50:0], (w_drem_sh >= w_den)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_cx    <= i_cx;
                        r_cy    <= i_cy;
                        r_cz    <= i_cz;
                        r_dot   <= '0;
                        r_n2    <= '0;
                        r_pd    <= '0;
                        r_pn    <= '0;
                        r_step  <= '0;
                        r_state <= SC_MUL;
                    end
                end
                SC_MUL: begin
                    // One product pair per cycle, added in on the next cycle.
                    r_pd   <= w_q * $signed({1'b0, w_c});
                    r_pn   <= w_c * w_c;
                    r_dot  <= w_dot_sum;
                    r_n2   <= w_n2_sum;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd3) begin
                        r_neg  <= w_dot_sum < 0;
                        r_mag  <= w_dot_sum < 0 ? 37'(-w_dot_sum) : 37'(w_dot_sum);
                        r_rad  <= {w_n2_sum[33:0], 28'd0};
                        r_rem  <= '0;
                        r_root <= '0;
                        r_step <= '0;
                        if (w_n2_sum == '0) begin
                            r_score <= '0;
                            r_state <= SC_DONE;
                        end else begin
                            r_state <= SC_SQRT;
                        end
                    end
                end
                SC_SQRT: begin
                    // Two radicand bits per cycle, one root bit out.
                    r_rad <= {r_rad[59:0], 2'b00};
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[29:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[29:0], 1'b0};
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd30) begin
                        r_num   <= 52'({r_mag, 15'd0})
                                   + 52'({r_root[29:0], (w_rem_sh >= w_trial)});
                        r_drem  <= '0;
                        r_quo   <= '0;
                        r_step  <= '0;
                        r_state <= SC_DIV;
                    end
                end
                SC_DIV: begin
                    // Restoring division of (mag * 2^15 + r) by 2r, rounding half up.
                    r_num  <= {r_num[50:0], 1'b0};
                    r_quo  <= w_quo_next;
                    r_drem <= (w_drem_sh >= w_den) ? w_drem_sh - w_den : w_drem_sh;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd51) begin
                        if (w_quo_next > 52'(ctks_pkg::SCORE_MAX)) begin
                            r_score <= r_neg ? -18'sd65536 : 18'sd65536;
                        end else begin
                            r_score <= r_neg ? -$signed(w_quo_next[17:0])
                                             : $signed(w_quo_next[17:0]);
                        end
                        r_state <= SC_DONE;
                    end
                end
                SC_DONE: begin
                    r_state <= SC_IDLE;
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == SC_DONE);
    assign o_score = r_score;

endmodule

@@ hw/rtl/ctks_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctks_cell: one place of the sorted hit chain
// Holds one kept entry; takes the new record, its upper neighbor or its lower one.
// ----------------------------------------------------------------------------
module ctks_cell (
    input  logic                 i_clk,
    input  ctks_pkg::t_cell_ctrl i_ctrl,
    input  ctks_pkg::t_entry     i_new,
    input  ctks_pkg::t_entry     i_prev,
    input  ctks_pkg::t_entry     i_next,
    input  logic                 i_prev_before,
    input  logic                 i_occupied,
    output ctks_pkg::t_entry     o_entry,
    output logic                 o_before
);

    ctks_pkg::t_entry r_entry;

    // The new record goes ahead of an empty place, a lower score, or an equal
    // score with a larger index.
    assign o_before = !i_occupied || (i_new.score > r_entry.score) ||
                      ((i_new.score == r_entry.score) && (i_new.index < r_entry.index));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_entry <= i_next;
        end else if (i_ctrl.ins) begin
            if (i_prev_before) begin
                r_entry <= i_prev;
            end else if (o_before) begin
                r_entry <= i_new;
            end
        end
    end

    assign o_entry = r_entry;

endmodule

@@ hw/rtl/ctks_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctks_chain: row of cells holding the best hits in rank order
// Insertion by local shifting; emission shifts toward the head.
// ----------------------------------------------------------------------------
module ctks_chain #(
    parameter int MAX_KEPT = 64,
    parameter int CNT_W    = $clog2(MAX_KEPT + 1)
) (
    input  logic                 i_clk,
    input  ctks_pkg::t_cell_ctrl i_ctrl,
    input  ctks_pkg::t_entry     i_new,
    input  logic [CNT_W-1:0]     i_count,
    output ctks_pkg::t_entry     o_head
);

    ctks_pkg::t_entry w_entry [MAX_KEPT];
    logic             w_before [MAX_KEPT];

    for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
        ctks_pkg::t_entry w_prev, w_next;
        logic w_prev_before, w_occ;

        if (g == 0) begin : g_first
            assign w_prev        = i_new;
            assign w_prev_before = 1'b0;
        end else begin : g_mid
            assign w_prev        = w_entry[g-1];
            assign w_prev_before = w_before[g-1];
        end
        if (g == MAX_KEPT - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end
        assign w_occ = (CNT_W'(g) < i_count);

        ctks_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (i_ctrl),
            .i_new         (i_new),
            .i_prev        (w_prev),
            .i_next        (w_next),
            .i_prev_before (w_prev_before),
            .i_occupied    (w_occ),
            .o_entry       (w_entry[g]),
            .o_before      (w_before[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

@@ hw/rtl/cosine_top_k_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_top_k_search_core: streaming cosine-similarity top-k search
// Scores records against a configured query and emits the best hits per run.
// ----------------------------------------------------------------------------
// Each record taken on the slave stream is scored as the cosine of its
// three 16-bit components against the signed Q1.16 query held in registers
// 0 to 2; an all-zero vector scores 0. The score comes from a sequential
// unit: multiply-accumulate, bit-serial square root and restoring
// division, in that order; an all-zero vector skips the root and the
// division. One record occupies the core from its transfer until it is
// scored and inserted, and s_axis_tready is high only between records.
// The scored record is then inserted into a chain of MAX_KEPT cells
// that keeps the hits sorted by descending score, the smaller record
// index first on equal scores. A record transferred with tlast closes
// the run: after it is kept, the best min(k, kept) hits leave on the
// master stream in rank order, one per cycle while the sink accepts,
// the last one with tlast, and the chain empties. k is register 3 (0
// reads as 5, larger values saturate to MAX_KEPT) and is read when the
// run closes. The user must see that configuration is written only while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cosine_top_k_search_core #(
    parameter int MAX_KEPT = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [ctks_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [ctks_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Record stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // record_index[23:0], comp_x[39:24], comp_y[55:40], comp_z[71:56],
    // sem_hash[135:72], document_ref[199:136], layer_port_bits[215:200]
    input  logic [215:0]                          s_axis_tdata,
    input  logic                                  s_axis_tlast,   // final_record
    // Hit stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // rank[5:0], hit_index[29:6], hit_score[47:30], hit_hash[111:48],
    // hit_layer[114:112], hit_ports[122:115], hit_docref[186:123], zero[191:187]
    output logic [191:0]                          m_axis_tdata,
    output logic                                  m_axis_tlast    // last_hit
);

    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCORE, S_INSERT, S_EMIT} t_state;

    t_state r_state;
    logic signed [ctks_pkg::QUERY_W-1:0] r_qx, r_qy, r_qz;
    logic [ctks_pkg::RC_W-1:0] r_rc;
    logic [CNT_W-1:0] r_count, r_emit_n, r_rank;
    logic r_final;
    logic r_start;
    ctks_pkg::t_entry r_rec;
    logic [ctks_pkg::COMP_W-1:0] r_cx, r_cy, r_cz;
    logic r_ovalid, r_olast;
    logic [191:0] r_odata;

    logic w_done;
    logic signed [ctks_pkg::SCORE_W-1:0] w_score;
    ctks_pkg::t_entry w_new, w_head;
    ctks_pkg::t_cell_ctrl w_ctrl;
    logic [CNT_W-1:0] w_count_inc;
    logic [7:0] w_k;
    logic [CNT_W-1:0] w_k_sat;
    logic w_load;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= 18'sd65536;
            r_qy <= '0;
            r_qz <= '0;
            r_rc <= ctks_pkg::RC_W'(ctks_pkg::DEFAULT_K);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ctks_pkg::REG_QUERY_X:      r_qx <= $signed(i_cfg_wdata);
                ctks_pkg::REG_QUERY_Y:      r_qy <= $signed(i_cfg_wdata);
                ctks_pkg::REG_QUERY_Z:      r_qz <= $signed(i_cfg_wdata);
                ctks_pkg::REG_RESULT_COUNT: r_rc <= i_cfg_wdata[ctks_pkg::RC_W-1:0];
                default: ;
            endcase
        end
    end

    ctks_scorer u_scorer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_qz    (r_qz),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_cz    (r_cz),
        .o_done  (w_done),
        .o_score (w_score)
    );

    always_comb begin
        w_new       = r_rec;
        w_new.score = w_score;
        w_load      = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);
        w_ctrl.ins  = (r_state == S_INSERT);
        w_ctrl.shift = w_load;
        w_count_inc = (r_count < CNT_W'(MAX_KEPT)) ? r_count + CNT_W'(1) : r_count;
        w_k = (r_rc == '0) ? 8'(ctks_pkg::DEFAULT_K) : 8'(r_rc);
        w_k_sat = (w_k > 8'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : CNT_W'(w_k);
    end

    ctks_chain #(.MAX_KEPT(MAX_KEPT), .CNT_W(CNT_W)) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_new   (w_new),
        .i_count (r_count),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_rank   <= '0;
        end else begin
            r_start <= 1'b0;
            // A hit taken by the sink leaves the register unless the next one loads.
            if (m_axis_tready && !w_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_rec.index  <= s_axis_tdata[23:0];
                        r_cx         <= s_axis_tdata[39:24];
                        r_cy         <= s_axis_tdata[55:40];
                        r_cz         <= s_axis_tdata[71:56];
                        r_rec.hash   <= s_axis_tdata[135:72];
                        r_rec.docref <= s_axis_tdata[199:136];
                        r_rec.lp     <= s_axis_tdata[210:200];
                        r_rec.score  <= '0;
                        r_final      <= s_axis_tlast;
                        r_start      <= 1'b1;
                        r_state      <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    if (w_done) begin
                        r_state <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    r_count <= w_count_inc;
                    r_rank  <= '0;
                    r_emit_n <= (w_k_sat < w_count_inc) ? w_k_sat : w_count_inc;
                    r_state <= r_final ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= (r_rank + CNT_W'(1) == r_emit_n);
                        r_odata  <= {5'd0, w_head.docref, w_head.lp[10:3], w_head.lp[2:0],
                                     w_head.hash, w_head.score, w_head.index,
                                     ctks_pkg::RANK_W'(r_rank)};
                        r_rank   <= r_rank + CNT_W'(1);
                        if (r_rank + CNT_W'(1) == r_emit_n) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

@@ hw/rtl/ctks_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctks_checker: port-level checks of the search core
// Watches the record and hit streams and is bound to the top level.
// ----------------------------------------------------------------------------
module ctks_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    // A stalled hit holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("hit changed while stalled");

    // Every record transfer starts a multi-cycle scoring pass.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("record taken while scoring");

    // Within a run the next hit follows at once with the next rank.
    a_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1))
        else $error("hit rank sequence broken");

    // No record is taken while a run is still being emitted.
    a_no_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("record stream open during emission");

endmodule

bind cosine_top_k_search_core ctks_checker u_ctks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/ctks_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctks_scoreboard: hit predictor and comparator for the cosine top-k search core
// Watches the configuration port and both streams, keeps its own ranked list
// of hits, and compares each hit transfer field by field with the prediction.
// ----------------------------------------------------------------------------
module ctks_scoreboard (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [17:0]  i_cfg_wdata,
    input  logic         i_rec_valid,
    input  logic         i_rec_ready,
    input  logic [215:0] i_rec_data,
    input  logic         i_rec_last,
    input  logic         i_hit_valid,
    input  logic         i_hit_ready,
    input  logic [191:0] i_hit_data,
    input  logic         i_hit_last,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int KEEP_MAX = 64;

    typedef struct {
        int         score;
        bit [23:0]  index;
        bit [63:0]  hash;
        bit [63:0]  docref;
        bit [10:0]  lp;
    } ranked_hit_t;

    typedef struct {
        bit [191:0] data;
        bit         last;
    } hit_word_t;

    longint      qry_x, qry_y, qry_z;
    bit [6:0]    hit_count_reg;
    ranked_hit_t ranked[$];
    hit_word_t   hits_due[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = hits_due.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int cosine_score(longint unsigned cx, longint unsigned cy,
                                        longint unsigned cz);
        longint unsigned n2, mag, r, q;
        longint          dot;
        n2 = cx * cx + cy * cy + cz * cz;
        if (n2 == 0) return 0;
        dot = qry_x * longint'(cx) + qry_y * longint'(cy) + qry_z * longint'(cz);
        mag = (dot < 0) ? longint'(-dot) : dot;
        r   = int_sqrt(n2 << 28);
        q   = ((mag << 14) * 2 + r) / (2 * r);
        if (q > ctks_pkg::SCORE_MAX) q = ctks_pkg::SCORE_MAX;
        return (dot < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic void report(string name, longint unsigned exp_v,
                                   longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        ranked_hit_t     e;
        hit_word_t       w;
        int              pos, k, n;
        if (!i_rst_n) begin
            qry_x         = 65536;
            qry_y         = 0;
            qry_z         = 0;
            hit_count_reg = 7'd5;
            ranked.delete();
            hits_due.delete();
            fails         = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ctks_pkg::REG_QUERY_X:      qry_x = longint'(signed'(i_cfg_wdata));
                    ctks_pkg::REG_QUERY_Y:      qry_y = longint'(signed'(i_cfg_wdata));
                    ctks_pkg::REG_QUERY_Z:      qry_z = longint'(signed'(i_cfg_wdata));
                    ctks_pkg::REG_RESULT_COUNT: hit_count_reg = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_rec_valid && i_rec_ready) begin
                e.index  = i_rec_data[23:0];
                e.score  = cosine_score(i_rec_data[39:24], i_rec_data[55:40],
                                        i_rec_data[71:56]);
                e.hash   = i_rec_data[135:72];
                e.docref = i_rec_data[199:136];
                e.lp     = i_rec_data[210:200];
                // Equal score and index stay behind the earlier arrival.
                pos = 0;
                while (pos < ranked.size() &&
                       !(e.score > ranked[pos].score ||
                         (e.score == ranked[pos].score && e.index < ranked[pos].index)))
                    pos++;
                if (pos < KEEP_MAX) begin
                    ranked.insert(pos, e);
                    if (ranked.size() > KEEP_MAX) void'(ranked.pop_back());
                end
                if (i_rec_last) begin
                    k = (hit_count_reg == 0) ? ctks_pkg::DEFAULT_K : hit_count_reg;
                    if (k > KEEP_MAX) k = KEEP_MAX;
                    n = (ranked.size() < k) ? ranked.size() : k;
                    for (int i = 0; i < n; i++) begin
                        w.data = '0;
                        w.data[5:0]     = i[5:0];
                        w.data[29:6]    = ranked[i].index;
                        w.data[47:30]   = ranked[i].score[17:0];
                        w.data[111:48]  = ranked[i].hash;
                        w.data[114:112] = ranked[i].lp[2:0];
                        w.data[122:115] = ranked[i].lp[10:3];
                        w.data[186:123] = ranked[i].docref;
                        w.last = (i == n - 1);
                        hits_due.push_back(w);
                    end
                    ranked.delete();
                end
            end
            if (i_hit_valid && i_hit_ready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected hit, expected none actual %0h",
                             $time, i_hit_data);
                    fails++;
                end else begin
                    w = hits_due.pop_front();
                    report("rank",   w.data[5:0],     i_hit_data[5:0]);
                    report("index",  w.data[29:6],    i_hit_data[29:6]);
                    report("score",  w.data[47:30],   i_hit_data[47:30]);
                    report("hash",   w.data[111:48],  i_hit_data[111:48]);
                    report("layer",  w.data[114:112], i_hit_data[114:112]);
                    report("ports",  w.data[122:115], i_hit_data[122:115]);
                    report("docref", w.data[186:123], i_hit_data[186:123]);
                    report("pad",    w.data[191:187], i_hit_data[191:187]);
                    report("last",   w.last,          i_hit_last);
                end
            end
        end
    end
endmodule

@@ tb/sv/tb_cosine_top_k_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_top_k_search_core: stimulus and verdict for the top-k search core
// Drives directed and random record runs under several query settings, with
// random idle bursts on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_cosine_top_k_search_core;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [17:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tlast;

    int fail_count;
    int hits_pending;
    int records_sent;
    bit quiet;        // no idling in the closing part of the run
    int sink_stall;

    // Last record sent, reused to build ties on score and index.
    logic [23:0] prev_idx;
    logic [15:0] prev_x, prev_y, prev_z;

    cosine_top_k_search_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ctks_scoreboard i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rec_valid  (s_axis_tvalid),
        .i_rec_ready  (s_axis_tready),
        .i_rec_data   (s_axis_tdata),
        .i_rec_last   (s_axis_tlast),
        .i_hit_valid  (m_axis_tvalid),
        .i_hit_ready  (m_axis_tready),
        .i_hit_data   (m_axis_tdata),
        .i_hit_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (hits_pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The hit sink stalls in random bursts until the closing part of the
    // run, where it accepts every transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end else if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= sink_stall - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= $urandom_range(0, 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offers one record and holds it until the core takes the transfer.
    // tvalid is dropped for a random gap before some records, except in the closing part.
    task automatic send_record(logic [23:0] idx, logic [15:0] cx, logic [15:0] cy,
                               logic [15:0] cz, logic [63:0] hash, logic [63:0] docref,
                               logic [15:0] lp, logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lp, docref, hash, cz, cy, cx, idx};
        s_axis_tlast  <= last;
        prev_idx = idx;
        prev_x   = cx;
        prev_y   = cy;
        prev_z   = cz;
        do @(posedge i_clk); while (!s_axis_tready);
        records_sent++;
    endtask

    // Holds the sender until every predicted hit has left, then lets a
    // record still in the scoring unit run out before configuration changes.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hits_pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_config(logic [17:0] qx, logic [17:0] qy, logic [17:0] qz,
                              logic [6:0] k);
        logic [17:0] vals [4];
        vals[0] = qx;
        vals[1] = qy;
        vals[2] = qz;
        vals[3] = {11'd0, k};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= i[1:0];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [17:0] rand_query();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'd0;
            3: return 18'($urandom);                // beyond +-1.0 of the Q1.16 scale too
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [6:0] rand_count();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return 7'($urandom_range(65, 126));
            default: return 7'($urandom_range(1, 20));
        endcase
    endfunction

    // One random record; a share repeat the previous vector and index so that
    // equal scores and equal indices meet in the ranking.
    task automatic send_random(logic last);
        logic [23:0] idx;
        logic [15:0] cx, cy, cz;
        int          mode;
        mode = $urandom_range(0, 9);
        idx  = 24'($urandom);
        cx   = 16'($urandom);
        cy   = 16'($urandom);
        cz   = 16'($urandom);
        if (mode == 0) begin
            idx = prev_idx;
            cx  = prev_x;
            cy  = prev_y;
            cz  = prev_z;
        end else if (mode == 1) begin
            cx = prev_x;
            cy = prev_y;
            cz = prev_z;
        end else if (mode == 2) begin
            cx = 16'd0;
            cy = 16'd0;
            cz = $urandom_range(0, 1) ? 16'd0 : cz;
        end else if (mode == 3) begin
            idx = 24'($urandom_range(0, 7));
            cx  = 16'($urandom_range(0, 3));
            cy  = 16'($urandom_range(0, 3));
            cz  = 16'($urandom_range(0, 3));
        end
        send_record(idx, cx, cy, cz, rand64(), rand64(), 16'($urandom), last);
    endtask

    initial begin
        int run_len;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        quiet         = 1'b0;
        records_sent  = 0;
        prev_idx = '0; prev_x = '0; prev_y = '0; prev_z = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset query, zero vector, field extremes, equal score and
        // index ties, then the run closes.
        send_record(24'd0, 16'd0, 16'd0, 16'd0, '0, '0, '0, 1'b0);
        send_record(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, 16'hFFFF, 1'b0);
        send_record(24'd5, 16'hFFFF, 16'd0, 16'd0, 64'h1, 64'h2, 16'h07FF, 1'b0);
        send_record(24'd5, 16'd1, 16'd0, 16'd0, 64'h3, 64'h4, 16'h0003, 1'b0);
        send_record(24'd3, 16'd7, 16'd0, 16'd0, 64'h5, 64'h6, 16'h07F8, 1'b0);
        send_record(24'd9, 16'd0, 16'hFFFF, 16'd0, 64'h7, 64'h8, 16'hF800, 1'b1);
        drain();

        // Negative and out-of-range query with every hit kept.
        set_config(-18'sd65536, 18'h1FFFF, 18'h20000, 7'd64);
        send_record(24'd1, 16'hFFFF, 16'd1, 16'd0, rand64(), rand64(), 16'($urandom), 1'b0);
        send_record(24'd2, 16'd0, 16'hFFFF, 16'hFFFF, rand64(), rand64(), 16'($urandom),
                    1'b0);
        send_record(24'd0, 16'd0, 16'd0, 16'd0, rand64(), rand64(), 16'($urandom), 1'b0);
        send_record(24'd4, 16'd1, 16'd1, 16'd1, rand64(), rand64(), 16'($urandom), 1'b1);
        drain();

        // A count of zero means five; a single-record run.
        set_config(18'd0, 18'sd65536, -18'sd65536, 7'd0);
        send_record(24'd8, 16'h8000, 16'h8000, 16'h0001, rand64(), rand64(),
                    16'($urandom), 1'b1);
        drain();

        // Random phases: new settings, then several runs; some runs overflow
        // the 64 kept entries so that low ranked records are dropped.
        while (records_sent < 400) begin
            if (records_sent > 340) quiet = 1'b1;
            set_config(rand_query(), rand_query(), rand_query(), rand_count());
            repeat ($urandom_range(1, 4)) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 90)
                                                      : $urandom_range(1, 12);
                // Keep the total close to the planned number of records.
                if (run_len > 420 - records_sent) run_len = 420 - records_sent;
                if (run_len < 1) run_len = 1;
                for (int i = 0; i < run_len - 1; i++) send_random(1'b0);
                send_random(1'b1);
            end
            drain();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hits_pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("cosine_top_k_search_core: match");
        end else begin
            $display("cosine_top_k_search_core: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("cosine_top_k_search_core: mismatch");
        $finish;
    end
endmodule
